// ===== rtl/etp_pkg.sv =====
package etp_pkg;

    localparam int NUM_FUNCS_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int ID_W   = 8;
    localparam int TIME_W = 31;
    localparam int CNT_W  = 32;
    localparam int ST_W   = 3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_PUSHED    = 3'd0;
    localparam logic [ST_W-1:0] ST_ENDED     = 3'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd3;
    localparam logic [ST_W-1:0] ST_REVERSED  = 3'd4;

    // One trace event as it sits in the queue between front and back.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              id_ok;
        logic              is_entry;
        logic [TIME_W-1:0] stamp;
    } t_evt;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// ===== rtl/etp_ram.sv =====
module etp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/etp_front.sv =====
module etp_front #(
    parameter int NUM_FUNCS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [etp_pkg::ID_W-1:0]     i_function_index,
    input  logic                         i_is_entry,
    input  logic [etp_pkg::TIME_W-1:0]   i_event_time,
    input  logic                         i_hold,
    output logic                         o_evt_valid,
    output etp_pkg::t_evt                o_evt,
    input  logic                         i_evt_take
);
    import etp_pkg::*;

    localparam logic [16:0] NF_L = 17'(NUM_FUNCS);

    t_evt       r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       accept;
    t_evt       evt_in;

    assign o_in_stall = (r_count == 2'd2) || i_hold;
    assign accept     = i_in_valid && !o_in_stall;

    // Classify the event on the way in; ids past the table keep no total.
    always_comb begin
        evt_in.id       = i_function_index;
        evt_in.id_ok    = ({9'b0, i_function_index} < NF_L);
        evt_in.is_entry = i_is_entry;
        evt_in.stamp    = i_event_time;
    end

    assign o_evt_valid = (r_count != 2'd0);
    assign o_evt       = r_slot[r_rptr];

    always_comb begin
        n_wptr  = accept ? !r_wptr : r_wptr;
        n_rptr  = i_evt_take ? !r_rptr : r_rptr;
        n_count = r_count + 2'(accept) - 2'(i_evt_take);
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slot[r_wptr] <= evt_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/etp_back.sv =====
module etp_back #(
    parameter int NUM_FUNCS   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_evt_valid,
    input  etp_pkg::t_evt                i_evt,
    output logic                         o_evt_take,
    output logic                         o_clearing,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [etp_pkg::ST_W-1:0]     o_status,
    output logic [etp_pkg::ID_W-1:0]     o_ended_function,
    output logic [etp_pkg::CNT_W-1:0]    o_self_time,
    output logic [etp_pkg::CNT_W-1:0]    o_running_total
);
    import etp_pkg::*;

    localparam int FW  = $clog2(NUM_FUNCS);
    localparam int SW  = $clog2(STACK_DEPTH);
    localparam int DW  = SW + 1;
    localparam int FRW = TIME_W + CNT_W;
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
    localparam logic [FW-1:0] CLR_LAST   = FW'(NUM_FUNCS - 1);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_EXEC  = 3'b010,
        S_WB    = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [FW-1:0]       r_clr_cnt, n_clr_cnt;
    logic [DW-1:0]       r_depth, n_depth;
    logic [TIME_W-1:0]   r_top_start, n_top_start;
    logic [CNT_W-1:0]    r_top_child, n_top_child;

    // Event held between the read and the write-back cycle.
    logic [ID_W-1:0]     r_id;
    logic [FW-1:0]       r_id_addr;
    logic                r_id_ok;
    logic [TIME_W-1:0]   r_stamp;
    logic [ST_W-1:0]     r_stat;
    logic [CNT_W-1:0]    r_incl;
    logic [CNT_W-1:0]    r_self;

    logic                r_out_valid, n_out_valid;
    logic [ST_W-1:0]     r_out_status;
    logic [ID_W-1:0]     r_out_id;
    logic [CNT_W-1:0]    r_out_self;
    logic [CNT_W-1:0]    r_out_total;

    logic                take;
    logic                out_free;
    logic                wb_go;
    logic [16:0]         id_ext;
    logic [FW-1:0]       id_addr;
    logic                reversed;
    logic [CNT_W-1:0]    incl_c;
    logic [CNT_W-1:0]    self_c;
    logic [ST_W-1:0]     stat_c;
    logic [DW-1:0]       depth_m1;
    logic [DW-1:0]       depth_m2;

    logic                tot_we;
    logic [FW-1:0]       tot_waddr;
    logic [CNT_W-1:0]    tot_wdata;
    logic [CNT_W-1:0]    tot_q;
    logic [CNT_W-1:0]    tot_cur;
    logic [CNT_W-1:0]    tot_new;

    logic                stk_we;
    logic [FRW-1:0]      stk_q;

    assign take     = (r_state == S_EXEC) && i_evt_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign wb_go    = (r_state == S_WB) && out_free;

    assign o_evt_take = take;
    assign o_clearing = (r_state == S_CLEAR);

    assign id_ext   = {9'b0, i_evt.id};
    assign id_addr  = id_ext[FW-1:0];
    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);

    // Classify against the current top frame.
    always_comb begin
        reversed = (i_evt.stamp < r_top_start);
        incl_c   = {1'b0, i_evt.stamp} - {1'b0, r_top_start} + CNT_W'(1);
        self_c   = (incl_c > r_top_child) ? (incl_c - r_top_child) : '0;
        if (i_evt.is_entry) begin
            stat_c = (r_depth >= DEPTH_FULL) ? ST_OVERFLOW : ST_PUSHED;
        end else if (r_depth == '0) begin
            stat_c = ST_UNDERFLOW;
        end else if (reversed) begin
            stat_c = ST_REVERSED;
        end else begin
            stat_c = ST_ENDED;
        end
    end

    // Totals update in the write-back cycle.
    always_comb begin
        tot_cur = r_id_ok ? tot_q : '0;
        tot_new = sat_add(tot_cur, r_self);
    end

    always_comb begin
        tot_we    = 1'b0;
        tot_waddr = r_id_addr;
        tot_wdata = tot_new;
        if (r_state == S_CLEAR) begin
            tot_we    = 1'b1;
            tot_waddr = r_clr_cnt;
            tot_wdata = '0;
        end else if (wb_go && (r_stat == ST_ENDED) && r_id_ok) begin
            tot_we = 1'b1;
        end
    end

    // A push spills the old top frame into the stack memory.
    assign stk_we = wb_go && (r_stat == ST_PUSHED) && (r_depth != '0);

    etp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_FUNCS)
    ) u_totals (
        .i_clk   (i_clk),
        .i_we    (tot_we),
        .i_waddr (tot_waddr),
        .i_wdata (tot_wdata),
        .i_re    (take),
        .i_raddr (id_addr),
        .o_rdata (tot_q)
    );

    etp_ram #(
        .WIDTH (FRW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (depth_m1[SW-1:0]),
        .i_wdata ({r_top_start, r_top_child}),
        .i_re    (take),
        .i_raddr (depth_m2[SW-1:0]),
        .o_rdata (stk_q)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_depth     = r_depth;
        n_top_start = r_top_start;
        n_top_child = r_top_child;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + FW'(1);
                if (r_clr_cnt == CLR_LAST) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (take) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    n_state     = S_EXEC;
                    n_out_valid = 1'b1;
                    if (r_stat == ST_PUSHED) begin
                        n_depth     = r_depth + DW'(1);
                        n_top_start = r_stamp;
                        n_top_child = '0;
                    end else if (r_stat == ST_ENDED) begin
                        n_depth = depth_m1;
                        if (r_depth >= DW'(2)) begin
                            n_top_start = stk_q[FRW-1:CNT_W];
                            n_top_child = sat_add(stk_q[CNT_W-1:0], r_incl);
                        end
                    end
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_start <= n_top_start;
        r_top_child <= n_top_child;
        if (take) begin
            r_id      <= i_evt.id;
            r_id_addr <= id_addr;
            r_id_ok   <= i_evt.id_ok;
            r_stamp   <= i_evt.stamp;
            r_stat    <= stat_c;
            r_incl    <= incl_c;
            r_self    <= (stat_c == ST_ENDED) ? self_c : '0;
        end
        if (wb_go) begin
            r_out_status <= r_stat;
            r_out_id     <= r_id;
            r_out_self   <= r_self;
            r_out_total  <= r_id_ok ? tot_new : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_ended_function = r_out_id;
    assign o_self_time      = r_out_self;
    assign o_running_total  = r_out_total;

endmodule

// ===== rtl/exclusive_time_profiler.sv =====
// Exclusive-time profiler: takes one pre-parsed trace event per transfer
// (function id, entry flag, timestamp) and returns exactly one result per
// event, in order: a status, the function id, the exclusive time credited by
// this event and that function's saturating running total. Open frames sit on
// a call stack whose top frame is kept in registers and whose lower frames
// live in a STACK_DEPTH-entry memory; per-function totals live in a
// NUM_FUNCS-entry memory. After reset the block sweeps the totals memory to
// zero, one entry per cycle, while the input stays stalled. The input side
// is a two-entry queue, so events are taken while earlier ones are still
// being worked on or a result waits in the output register. The back-end
// engine takes no new event until it is through with the last: it reads the
// parent frame and the function's total in its execute state and writes them
// back in its write-back state. An accepted event passes through the input
// queue, the engine's execute and write-back states and the output register.
module exclusive_time_profiler #(
    parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [etp_pkg::ID_W-1:0]     i_function_index,
    input  logic                         i_is_entry,
    input  logic [etp_pkg::TIME_W-1:0]   i_event_time,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [etp_pkg::ST_W-1:0]     o_status,
    output logic [etp_pkg::ID_W-1:0]     o_ended_function,
    output logic [etp_pkg::CNT_W-1:0]    o_self_time,
    output logic [etp_pkg::CNT_W-1:0]    o_running_total
);
    import etp_pkg::*;

    logic evt_valid;
    t_evt evt;
    logic evt_take;
    logic clearing;

    // Front end: accepts transfers, tags ids that have no table entry, and
    // queues them so the input keeps moving while the engine is busy.
    etp_front #(
        .NUM_FUNCS (NUM_FUNCS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_function_index (i_function_index),
        .i_is_entry       (i_is_entry),
        .i_event_time     (i_event_time),
        .i_hold           (clearing),
        .o_evt_valid      (evt_valid),
        .o_evt            (evt),
        .i_evt_take       (evt_take)
    );

    // Back end: the call stack, the totals table and the output register.
    // Pushes, pops, error checks and saturating updates all happen here.
    etp_back #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_evt_valid      (evt_valid),
        .i_evt            (evt),
        .o_evt_take       (evt_take),
        .o_clearing       (clearing),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_ended_function (o_ended_function),
        .o_self_time      (o_self_time),
        .o_running_total  (o_running_total)
    );

endmodule

// ===== rtl/etp_checker.sv =====
module etp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [etp_pkg::ST_W-1:0]     o_status,
    input logic [etp_pkg::ID_W-1:0]     o_ended_function,
    input logic [etp_pkg::CNT_W-1:0]    o_self_time,
    input logic [etp_pkg::CNT_W-1:0]    o_running_total
);
    import etp_pkg::*;

    // Reset empties the output and starts the clearing sweep.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open right after reset");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_ended_function) && $stable(o_self_time)
            && $stable(o_running_total))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_PUSHED) || (o_status == ST_ENDED)
            || (o_status == ST_OVERFLOW) || (o_status == ST_UNDERFLOW)
            || (o_status == ST_REVERSED))
        else $error("unknown status code");

    // Only a completed end event credits any time.
    a_self_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_ENDED) |-> (o_self_time == '0))
        else $error("time credited by an event that did not end a frame");

endmodule

bind exclusive_time_profiler etp_checker u_etp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_ended_function (o_ended_function),
    .o_self_time      (o_self_time),
    .o_running_total  (o_running_total)
);
